### hdl/sktbl_pkg.sv
package sktbl_pkg;

   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int CNT_W    = 7;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

### hdl/sktbl_if.sv
interface sktbl_req_if
   import sktbl_pkg::*;
   #(parameter int KEY_BITS = 32, parameter int PAYLOAD_BITS = 32) ();
   logic                        valid;
   logic                        ready;
   logic [REQ_W-1:0]            req_type;
   logic signed [KEY_BITS-1:0]  search_key;
   logic [PAYLOAD_BITS-1:0]     entry_payload;

   modport source (output valid, req_type, search_key, entry_payload, input ready);
   modport sink   (input valid, req_type, search_key, entry_payload, output ready);
endinterface

interface sktbl_rsp_if
   import sktbl_pkg::*;
   #(parameter int PAYLOAD_BITS = 32) ();
   logic                        valid;
   logic                        ready;
   logic [STATUS_W-1:0]         status;
   logic [POS_W-1:0]            position;
   logic [PAYLOAD_BITS-1:0]     found_payload;
   logic [CNT_W-1:0]            entry_count;

   modport source (output valid, status, position, found_payload, entry_count, input ready);
   modport sink   (input valid, status, position, found_payload, entry_count, output ready);
endinterface

### hdl/sktbl_mem.sv
module sktbl_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sorted_key_table_top.sv
// sorted_key_table_top: a table of up to TABLE_DEPTH {key, payload} entries kept
// in ascending signed key order in one simple dual-port RAM (registered read).
// req_chan (valid/ready) carries one request beat: insert, lookup or delete.
// rsp_chan (valid/ready) returns exactly one result beat per request:
// status, sorted position, payload found and entry count after the request.
// Requests are worked one at a time; req_chan.ready is high only while idle.
// A search is a binary search over the n entries held in at most ceil(log2(n+1))
// probes; a probe is read issue plus compare. A lookup ends on a hit or when the
// bounds meet. An insert shifts the entries at and above its slot up one slot,
// one entry per cycle through the RAM ports (none when its slot is at the end),
// then the new entry lands; a delete that hits shifts the entries above it down
// one slot, unless the last entry goes. An insert into a full table or an unused
// request code goes straight to the result. The next request is taken once the
// sequencer is back in idle.
// A result beat sits in an output register; the next request is accepted
// while it waits. A stalled receiver holds a finished request in its last
// step until the output register frees up.
// Reset (synchronous, active high) empties the table at once via the fill
// count; RAM contents are never cleared and words beyond the fill count are never used.
module sorted_key_table_top
   import sktbl_pkg::*;
#(
   parameter int TABLE_DEPTH  = 64,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   sktbl_req_if.sink     req_chan,
   sktbl_rsp_if.source   rsp_chan
);

   localparam int AW = $clog2(TABLE_DEPTH);       // entry index
   localparam int CW = $clog2(TABLE_DEPTH + 1);   // fill count, search bounds
   localparam int EW = KEY_BITS + PAYLOAD_BITS;   // RAM word: {order code, payload}

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_PRB_RD  = 3'd1;  // pick midpoint, issue read
   localparam logic [2:0] S_PRB_CMP = 3'd2;  // compare read key, narrow bounds
   localparam logic [2:0] S_SHIFT   = 3'd3;  // stream entries up or down one slot
   localparam logic [2:0] S_DRAIN   = 3'd4;  // last shifted write
   localparam logic [2:0] S_PUT     = 3'd5;  // write the inserted entry
   localparam logic [2:0] S_FINISH  = 3'd6;  // hand result to output register

   logic [2:0]              state_ff, state_in;
   logic [REQ_W-1:0]        op_ff, op_in;
   logic [KEY_BITS-1:0]     code_ff, code_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           lo_ff, lo_in;
   logic [CW-1:0]           hx_ff, hx_in;     // exclusive upper bound
   logic [AW-1:0]           mid_ff, mid_in;
   logic [AW-1:0]           at_ff, at_in;
   logic [AW-1:0]           src_ff, src_in;
   logic [AW-1:0]           dst_ff, dst_in;
   logic                    pend_ff, pend_in;
   logic [STATUS_W-1:0]     st_ff, st_in;
   logic [PAYLOAD_BITS-1:0] found_ff, found_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [AW-1:0]           rsp_pos_ff, rsp_pos_in;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff, rsp_pay_in;
   logic [CW-1:0]           rsp_cnt_ff, rsp_cnt_in;

   // RAM port signals
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [EW-1:0]           wr_data;
   logic [AW-1:0]           rd_addr;
   logic [EW-1:0]           rd_data;
   logic [KEY_BITS-1:0]     rd_key;
   logic [PAYLOAD_BITS-1:0] rd_pay;

   logic [CW:0]             mid_sum;
   logic [CW-1:0]           mid_full;
   logic [CW-1:0]           mid_next;   // mid + 1 at count width
   logic                    req_fire;
   logic                    rsp_load;
   logic                    is_insert;

   logic [AW+POS_W-1:0]     pos_wide;
   logic [CW+CNT_W-1:0]     cnt_wide;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   assign is_insert = (op_ff == REQ_INSERT);

   assign rd_key = rd_data[EW-1:PAYLOAD_BITS];
   assign rd_pay = rd_data[PAYLOAD_BITS-1:0];

   // midpoint of [lo, hx-1]; only used while lo < hx
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hx_ff} - (CW+1)'(1);
   assign mid_full = mid_sum[CW:1];
   assign mid_next = CW'(mid_ff) + CW'(1);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      code_in  = code_ff;
      pay_in   = pay_ff;
      cnt_in   = cnt_ff;
      lo_in    = lo_ff;
      hx_in    = hx_ff;
      mid_in   = mid_ff;
      at_in    = at_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      pend_in  = 1'b0;
      st_in    = st_ff;
      found_in = found_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.req_type;
               // flip the sign bit: unsigned compare then follows signed order
               code_in  = {~req_chan.search_key[KEY_BITS-1],
                           req_chan.search_key[KEY_BITS-2:0]};
               pay_in   = req_chan.entry_payload;
               lo_in    = '0;
               hx_in    = cnt_ff;
               at_in    = '0;
               found_in = '0;
               st_in    = ST_NOT_FOUND;
               case (req_chan.req_type)
                  REQ_INSERT: begin
                     if (cnt_ff == CW'(TABLE_DEPTH)) begin
                        st_in    = ST_FULL;
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_PRB_RD;
                     end
                  end
                  REQ_LOOKUP, REQ_DELETE: begin
                     state_in = S_PRB_RD;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_PRB_RD: begin
            if (lo_ff < hx_ff) begin
               mid_in   = mid_full[AW-1:0];
               state_in = S_PRB_CMP;
            end else if (is_insert) begin
               // upper bound found: slot after all equal keys
               at_in = lo_ff[AW-1:0];
               if (cnt_ff > lo_ff) begin
                  src_in   = AW'(cnt_ff - CW'(1));
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_PUT;
               end
            end else begin
               state_in = S_FINISH;
            end
         end

         S_PRB_CMP: begin
            state_in = S_PRB_RD;
            if (is_insert) begin
               if (rd_key > code_ff) begin
                  hx_in = CW'(mid_ff);
               end else begin
                  lo_in = mid_next;
               end
            end else if (rd_key == code_ff) begin
               at_in    = mid_ff;
               found_in = rd_pay;
               st_in    = ST_DONE;
               if (op_ff == REQ_DELETE) begin
                  if (mid_next < cnt_ff) begin
                     src_in   = mid_next[AW-1:0];
                     state_in = S_SHIFT;
                  end else begin
                     cnt_in   = cnt_ff - CW'(1);
                     state_in = S_FINISH;
                  end
               end else begin
                  state_in = S_FINISH;
               end
            end else if (rd_key < code_ff) begin
               lo_in = mid_next;
            end else begin
               hx_in = CW'(mid_ff);
            end
         end

         S_SHIFT: begin
            // one read per cycle; the previous read lands one slot over
            pend_in = 1'b1;
            if (is_insert) begin
               dst_in = src_ff + AW'(1);
               if (src_ff == at_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  src_in = src_ff - AW'(1);
               end
            end else begin
               dst_in = src_ff - AW'(1);
               if (CW'(src_ff) + CW'(1) == cnt_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  src_in = src_ff + AW'(1);
               end
            end
         end

         S_DRAIN: begin
            if (is_insert) begin
               state_in = S_PUT;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_FINISH;
            end
         end

         S_PUT: begin
            cnt_in   = cnt_ff + CW'(1);
            st_in    = ST_DONE;
            state_in = S_FINISH;
         end

         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // RAM access
   always_comb begin
      rd_addr = (state_ff == S_PRB_RD) ? mid_full[AW-1:0] : src_ff;
      wr_en   = (state_ff == S_SHIFT && pend_ff) || (state_ff == S_DRAIN)
                || (state_ff == S_PUT);
      if (state_ff == S_PUT) begin
         wr_addr = at_ff;
         wr_data = {code_ff, pay_ff};
      end else begin
         wr_addr = dst_ff;
         wr_data = rd_data;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = st_ff;
         rsp_pos_in    = at_ff;
         rsp_pay_in    = found_ff;
         rsp_cnt_in    = cnt_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      code_ff       <= code_in;
      pay_ff        <= pay_in;
      lo_ff         <= lo_in;
      hx_ff         <= hx_in;
      mid_ff        <= mid_in;
      at_ff         <= at_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      st_ff         <= st_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   sktbl_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // position and count leave modulo their field widths
   assign pos_wide = (AW+POS_W)'(rsp_pos_ff);
   assign cnt_wide = (CW+CNT_W)'(rsp_cnt_ff);

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.position      = pos_wide[POS_W-1:0];
   assign rsp_chan.found_payload = rsp_pay_ff;
   assign rsp_chan.entry_count   = cnt_wide[CNT_W-1:0];

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> rsp_cnt_ff == CW'(TABLE_DEPTH))
      else $error("table full reported with room left");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_PRB_RD || state_ff == S_PRB_CMP) |-> !wr_en)
      else $error("RAM write outside shift or put");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> CW'(src_ff) < cnt_ff)
      else $error("shift source beyond fill count");

   a_cnt_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && cnt_ff != $past(cnt_ff)) |->
         ($past(state_ff) == S_PUT || $past(state_ff) == S_DRAIN
          || $past(state_ff) == S_PRB_CMP))
      else $error("fill count changed outside an insert or delete");
`endif

endmodule
